// File: hdl/scf_pkg.sv
// Shared types, constants and helpers for the sample channel filter.
package scf_pkg;

  localparam int MedianMax = 8;
  localparam int IdxW      = $clog2(MedianMax);
  localparam int CntW      = $clog2(MedianMax + 1);

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegWindow = 3'd1;
  localparam logic [2:0] RegAlpha  = 3'd2;
  localparam logic [2:0] RegB0     = 3'd3;
  localparam logic [2:0] RegB1     = 3'd4;
  localparam logic [2:0] RegA1     = 3'd5;
  localparam logic [2:0] RegA2     = 3'd6;

  localparam logic [1:0] ModePass   = 2'd0;
  localparam logic [1:0] ModeMedian = 2'd1;
  localparam logic [1:0] ModeAvg    = 2'd2;
  localparam logic [1:0] ModeBiquad = 2'd3;

  // multiplier operation select
  typedef enum logic [1:0] {
    MulPass,
    MulAdd,
    MulSub
  } mul_op_t;

  // saturate a 66-bit signed value to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd140737488355327;
    lo = -66'sd140737488355328;
    if (v > hi) sat48 = hi[47:0];
    else if (v < lo) sat48 = lo[47:0];
    else sat48 = v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
    if (v > 66'sd8388607) sat24 = 24'sh7fffff;
    else if (v < -66'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[23:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
    if (v > 66'sd549755813887) sat40 = 40'sh7fffffffff;
    else if (v < -66'sd549755813888) sat40 = 40'sh8000000000;
    else sat40 = v[39:0];
  endfunction

endpackage

// File: hdl/scf_mul.sv
// Shared registered signed multiplier with rounding shift and accumulate.
module scf_mul (
  input  logic                clk,
  input  logic                en,
  input  logic signed [32:0]  op_a,
  input  logic signed [32:0]  op_b,
  input  logic [4:0]          shift,
  input  logic signed [65:0]  addend,
  input  scf_pkg::mul_op_t    op,
  output logic signed [65:0]  result
);
  import scf_pkg::*;

  logic signed [65:0] prod;
  logic signed [65:0] rounded;
  logic signed [65:0] result_r;
  logic signed [65:0] result_nxt;

  // round half up, then combine with the addend
  always_comb begin
    prod = 66'(op_a) * 66'(op_b);
    rounded = (prod + ((66'sd1 <<< shift) >>> 1)) >>> shift;
    case (op)
      MulAdd:  result_nxt = addend + rounded;
      MulSub:  result_nxt = addend - rounded;
      default: result_nxt = rounded;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) result_r <= result_nxt;
  end

  assign result = result_r;
endmodule

// File: hdl/scf_median.sv
// Median ring store with an insertion sort stepped one compare per cycle.
module scf_median (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr,
  input  logic                           start,
  input  logic signed [23:0]             sample,
  input  logic [3:0]                     win_len,
  output logic                           done,
  output logic signed [23:0]             median
);
  import scf_pkg::*;

  typedef enum logic [1:0] {
    Idle,
    Load,
    Sort,
    Finish
  } state_t;

  logic signed [23:0] ring_r [MedianMax];
  logic signed [23:0] srt_r  [MedianMax];
  logic [IdxW-1:0]    wpos_r;
  logic [CntW-1:0]    fill_r;
  logic [CntW-1:0]    n_r;
  logic [CntW-1:0]    i_r;
  logic [CntW-1:0]    j_r;
  logic signed [23:0] key_r;
  state_t             state_r;
  logic               done_r;
  logic signed [23:0] median_r;
  logic [CntW-1:0]    w_eff;
  logic [CntW-1:0]    fill_nxt;
  logic [IdxW-1:0]    wpos_nxt;
  logic [CntW-1:0]    wrap_v;

  // clamp the window length and wrap the write position modulo the window
  always_comb begin
    if (win_len == 4'd0) w_eff = CntW'(1);
    else if (32'(win_len) > MedianMax) w_eff = CntW'(MedianMax);
    else w_eff = CntW'(win_len);
    wrap_v = CntW'(wpos_r) + CntW'(1);
    for (int k = 0; k < MedianMax; k++) begin
      if (wrap_v >= w_eff) wrap_v = wrap_v - w_eff;
    end
    wpos_nxt = wrap_v[IdxW-1:0];
    fill_nxt = (fill_r < w_eff) ? fill_r + CntW'(1) : fill_r;
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n || clr) begin
      state_r <= Idle;
      wpos_r  <= '0;
      fill_r  <= '0;
      for (int k = 0; k < MedianMax; k++) ring_r[k] <= '0;
    end else begin
      case (state_r)
        Idle: begin
          if (start) begin
            ring_r[wpos_r] <= sample;
            wpos_r  <= wpos_nxt;
            fill_r  <= fill_nxt;
            n_r     <= (fill_nxt > CntW'(MedianMax)) ? CntW'(MedianMax) : fill_nxt;
            state_r <= Load;
          end
        end
        Load: begin
          for (int k = 0; k < MedianMax; k++) srt_r[k] <= ring_r[k];
          i_r     <= CntW'(1);
          j_r     <= CntW'(1);
          key_r   <= ring_r[(MedianMax > 1) ? 1 : 0];
          state_r <= (n_r > CntW'(1)) ? Sort : Finish;
        end
        Sort: begin
          // one compare and shift of the insertion sort
          if (j_r != '0 && srt_r[j_r[IdxW-1:0] - IdxW'(1)] > key_r) begin
            srt_r[j_r[IdxW-1:0]] <= srt_r[j_r[IdxW-1:0] - IdxW'(1)];
            j_r <= j_r - CntW'(1);
          end else begin
            srt_r[j_r[IdxW-1:0]] <= key_r;
            if (i_r + CntW'(1) >= n_r) begin
              state_r <= Finish;
            end else begin
              i_r   <= i_r + CntW'(1);
              j_r   <= i_r + CntW'(1);
              key_r <= srt_r[i_r[IdxW-1:0] + IdxW'(1)];
            end
          end
        end
        Finish: begin
          median_r <= srt_r[n_r[IdxW:1]];
          done_r   <= 1'b1;
          state_r  <= Idle;
        end
        default: state_r <= Idle;
      endcase
    end
  end

  assign done   = done_r;
  assign median = median_r;
endmodule

// File: hdl/sample_channel_filter.sv
// Top level of the sample channel filter: sequencer, state and result register.
// Sample channel filter.
// The input channel (in_valid/in_ready) carries a command bit and a signed
// 24-bit sample. Command 1 clears all filter state and yields no result;
// command 0 filters the sample in the mode set through the cfg_ port and
// yields one word on the output channel (out_valid/out_ready).
// One item is handled at a time. Pass-through registers the sample straight
// into the output register, the exponential average takes two products
// (the first sample seeds the average and passes straight through), the
// biquad five sequential products through one shared 33x33 multiplier (the
// first sample adds the seeding states BqSeed1, BqSeed2 and BqY2), and the
// median waits for the one-compare-per-cycle insertion sort over the ring.
// The result sits in an output register; in_ready stays low until it is
// taken, so a stalled receiver holds the block.
// Reset (rst_n low at a clock edge) restores register defaults and clears
// the ring, the averaging and the biquad state; configuration writes are
// taken at any time but are meant for idle periods and never clear state.
module sample_channel_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [23:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_filtered,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import scf_pkg::*;

  typedef enum logic [3:0] {
    Idle,
    AvgMul,
    AvgHi,
    AvgOut,
    BqSeed1,
    BqSeed2,
    BqY,
    BqY2,
    BqD1a,
    BqD1b,
    BqD2a,
    BqD2b,
    MedWait,
    Hold
  } state_t;

  logic [1:0]          mode_r;
  logic [3:0]          win_r;
  logic [16:0]         alpha_r;
  logic signed [31:0]  b0_r, b1_r, a1_r, a2_r;
  logic                seeded_r;
  logic signed [39:0]  avg_r;
  logic signed [47:0]  d1_r, d2_r;
  logic signed [31:0]  y_r;
  logic signed [23:0]  x_r;
  state_t              state_r;
  logic                out_valid_r;
  logic signed [23:0]  out_r;

  logic                clr;
  logic                med_start, med_done;
  logic signed [23:0]  med_val;
  logic                mul_en;
  logic signed [32:0]  mul_a, mul_b;
  logic [4:0]          mul_sh;
  logic signed [65:0]  mul_add, mul_res;
  mul_op_t             mul_op;
  logic [16:0]         alpha_c;
  logic signed [65:0]  xs;
  logic signed [65:0]  avg_diff;

  assign in_ready = (state_r == Idle) && !out_valid_r;
  assign clr = in_valid && in_ready && in_command;
  assign med_start = in_valid && in_ready && !in_command && mode_r == ModeMedian;
  assign alpha_c = alpha_r[16] ? 17'd65536 : alpha_r;
  assign xs = 66'(x_r) <<< 16;
  assign avg_diff = xs - 66'(avg_r);

  scf_median u_median (
    .clk(clk), .rst_n(rst_n), .clr(clr), .start(med_start), .sample(in_sample),
    .win_len(win_r), .done(med_done), .median(med_val)
  );

  // drive the shared multiplier for the current step
  always_comb begin
    mul_en  = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = 5'd22;
    mul_add = '0;
    mul_op  = MulPass;
    case (state_r)
      AvgMul: begin
        // low 16 bits of the difference, rounded into place
        mul_a = 33'(alpha_c);
        mul_b = {17'd0, avg_diff[15:0]};
        mul_sh = 5'd16;
      end
      AvgHi: begin
        // upper part of the difference lands unshifted
        mul_a = 33'(alpha_c);
        mul_b = 33'(avg_diff >>> 16);
        mul_sh = 5'd0;
        mul_add = 66'(avg_r) + mul_res;
        mul_op = MulAdd;
      end
      BqSeed1: begin
        mul_a = 33'(x_r);
        mul_b = 33'sh040000000 - 33'(b0_r);
      end
      BqSeed2: begin
        mul_a = 33'(x_r);
        mul_b = 33'(b0_r) - 33'(a2_r);
      end
      BqY: begin
        mul_a = 33'(x_r); mul_b = 33'(b0_r);
        mul_add = 66'(d1_r); mul_op = MulAdd;
      end
      BqD1a: begin
        mul_a = 33'(x_r); mul_b = 33'(b1_r);
        mul_add = 66'(d2_r); mul_op = MulAdd;
      end
      BqD1b: begin
        mul_a = 33'(y_r); mul_b = 33'(a1_r); mul_sh = 5'd30;
        mul_add = mul_res; mul_op = MulSub;
      end
      BqD2a: begin
        mul_a = 33'(x_r); mul_b = 33'(b0_r);
      end
      BqD2b: begin
        mul_a = 33'(y_r); mul_b = 33'(a2_r); mul_sh = 5'd30;
        mul_add = mul_res; mul_op = MulSub;
      end
      default: mul_en = 1'b0;
    endcase
  end

  scf_mul u_mul (
    .clk(clk), .en(mul_en), .op_a(mul_a), .op_b(mul_b), .shift(mul_sh),
    .addend(mul_add), .op(mul_op), .result(mul_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModePass; win_r <= 4'd1; alpha_r <= 17'd65536;
      b0_r <= '0; b1_r <= '0; a1_r <= '0; a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMode:   mode_r  <= cfg_data[1:0];
        RegWindow: win_r   <= cfg_data[3:0];
        RegAlpha:  alpha_r <= cfg_data[16:0];
        RegB0:     b0_r    <= cfg_data;
        RegB1:     b1_r    <= cfg_data;
        RegA1:     a1_r    <= cfg_data;
        RegA2:     a2_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Idle; out_valid_r <= 1'b0; seeded_r <= 1'b0;
      avg_r <= '0; d1_r <= '0; d2_r <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        Idle: begin
          if (in_valid && in_ready) begin
            x_r <= in_sample;
            if (in_command) begin
              seeded_r <= 1'b0; avg_r <= '0; d1_r <= '0; d2_r <= '0;
            end else begin
              case (mode_r)
                ModeMedian: state_r <= MedWait;
                ModeAvg: begin
                  if (!seeded_r) begin
                    avg_r <= 40'(in_sample) <<< 16;
                    seeded_r <= 1'b1;
                    out_r <= in_sample;
                    out_valid_r <= 1'b1;
                  end else state_r <= AvgMul;
                end
                ModeBiquad: state_r <= seeded_r ? BqY : BqSeed1;
                default: begin
                  out_r <= in_sample;
                  out_valid_r <= 1'b1;
                end
              endcase
            end
          end
        end
        AvgMul: state_r <= AvgHi;
        AvgHi: state_r <= AvgOut;
        AvgOut: begin
          avg_r <= sat40(mul_res);
          out_r <= sat24((66'(sat40(mul_res)) + 66'sd32768) >>> 16);
          out_valid_r <= 1'b1;
          state_r <= Idle;
        end
        BqSeed1: state_r <= BqSeed2;
        BqSeed2: begin
          d1_r <= sat48(mul_res);
          state_r <= BqY2;
        end
        BqY2: begin
          d2_r <= sat48(mul_res);
          seeded_r <= 1'b1;
          state_r <= BqY;
        end
        BqY: state_r <= BqD1a;
        BqD1a: begin
          y_r <= sat32(mul_res);
          state_r <= BqD1b;
        end
        BqD1b: state_r <= BqD2a;
        BqD2a: begin
          d1_r <= sat48(mul_res);
          state_r <= BqD2b;
        end
        BqD2b: state_r <= Hold;
        Hold: begin
          d2_r <= sat48(mul_res);
          out_r <= sat24((66'(y_r) + 66'sd128) >>> 8);
          out_valid_r <= 1'b1;
          state_r <= Idle;
        end
        MedWait: begin
          if (med_done) begin
            out_r <= med_val;
            out_valid_r <= 1'b1;
            state_r <= Idle;
          end
        end
        default: state_r <= Idle;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_r;
endmodule

// File: hdl/scf_checker.sv
// Port-level checker for the sample channel filter, bound to the top level.
module scf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_filtered
);
  // held word stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("output word changed while stalled");

  // never ready while a result is pending
  a_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready with a pending word");

  // a clear yields no word next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command |=> !out_valid)
    else $error("word after clear");

  // an accept drops ready for the next cycle unless it was a clear
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command |=> !in_ready)
    else $error("ready right after accepting a sample");
endmodule

bind sample_channel_filter scf_checker u_scf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_command(in_command), .out_valid(out_valid), .out_ready(out_ready),
  .out_filtered(out_filtered)
);
